// ----- rtl/ipru_pkg.sv -----
package ipru_pkg;

    localparam int PIX_W       = 24;
    localparam int SCALE_W     = 7;
    localparam int SRC_WIDTH_W = 13;
    localparam int REPLAY_W    = 6;
    localparam int PAD_W       = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 1;
    localparam int S_DATA_W    = 24;
    localparam int M_DATA_W    = 32;
    localparam int M_USER_W    = 3;

    localparam int DEF_MAX_WIDTH = 4096;
    localparam int DEF_MAX_SCALE = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE     = 1'b0,
        CFG_SRC_WIDTH = 1'b1
    } cfg_index_t;

    typedef enum logic {
        FUNC_SOURCE = 1'b0,
        FUNC_REPLAY = 1'b1
    } func_t;

    // Zero bytes that bring width*scale*3 bytes up to a multiple of four.
    function automatic logic [PAD_W-1:0] pad_calc(input logic [1:0] w_lo,
                                                  input logic [1:0] s_lo);
        logic [3:0] prod;
        begin
            prod = 4'(w_lo) * 4'(s_lo) * 4'd3;
            return PAD_W'(4'd0 - prod);
        end
    endfunction

endpackage

// ----- rtl/ipru_ram.sv -----
module ipru_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// ----- rtl/integer_pixel_replication_upscaler.sv -----
// Nearest-neighbor integer upscaler for 24-bit pixels. Each source request (tuser 0) is
// stored in a line store at the current column and sent out scale times, one pixel per
// cycle while the sink is ready; after a full source row the block expects scale-1
// replayed rows, each replay request (tuser 1) reading the stored pixel of the current
// column and sending it scale times. A request of the wrong kind gives one result with
// the rejected flag set and changes nothing. The last pixel of each output row carries
// row_end and the count of zero padding bytes for a four-byte row. The block takes one
// request at a time and takes no new one until the last pixel of the current one is
// sent; a replay request first passes through a state for the line store read, and
// the output counter sends one pixel per cycle when the sink is ready.
module integer_pixel_replication_upscaler #(
    parameter int MAX_WIDTH = ipru_pkg::DEF_MAX_WIDTH,
    parameter int MAX_SCALE = ipru_pkg::DEF_MAX_SCALE
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ipru_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ipru_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ipru_pkg::S_DATA_W-1:0]   s_tdata,  // source_pixel[23:0]
    input  logic                            s_tuser,  // func
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ipru_pkg::M_DATA_W-1:0]   m_tdata,  // out_pixel[23:0], pad_bytes[25:24]
    output logic [ipru_pkg::M_USER_W-1:0]   m_tuser,  // row_end, replay_due, rejected
    output logic                            m_tlast
);

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = ($clog2(MAX_WIDTH + 1) > ipru_pkg::SRC_WIDTH_W)
                        ? $clog2(MAX_WIDTH + 1) : ipru_pkg::SRC_WIDTH_W;
    localparam int SW = ipru_pkg::SCALE_W;
    localparam int RW = ipru_pkg::REPLAY_W;
    localparam int PW = ipru_pkg::PIX_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } state_t;

    state_t                            state_reg, state_next;
    logic [SW-1:0]                     scale_reg, scale_next;
    logic [ipru_pkg::SRC_WIDTH_W-1:0]  width_reg, width_next;
    logic [COL_W-1:0]                  column_reg, column_next;
    logic [RW-1:0]                     replays_reg, replays_next;
    logic                              phase_reg, phase_next;
    logic [SW-1:0]                     count_reg, count_next;
    logic [SW-1:0]                     total_reg, total_next;
    logic [PW-1:0]                     pix_reg, pix_next;
    logic [ipru_pkg::PAD_W-1:0]        pad_reg, pad_next;
    logic                              rend_reg, rend_next;
    logic                              rej_reg, rej_next;

    logic [SW-1:0]       eff_scale;
    logic [WW-1:0]       eff_width;
    logic                accept;
    logic                out_fire;
    logic                fin;
    logic                rend;
    logic [RW-1:0]       replays_inc;
    logic [PW-1:0]       ram_rdata;
    logic                ram_we;
    logic                ram_re;

    always_comb
    begin
        eff_scale = scale_reg;
        if (scale_reg == '0)
        begin
            eff_scale = SW'(1);
        end
        else if (scale_reg > SW'(MAX_SCALE))
        begin
            eff_scale = SW'(MAX_SCALE);
        end

        eff_width = WW'(width_reg);
        if (width_reg == '0)
        begin
            eff_width = WW'(1);
        end
        else if (WW'(width_reg) > WW'(MAX_WIDTH))
        begin
            eff_width = WW'(MAX_WIDTH);
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == ST_EMIT);
    assign out_fire = m_tvalid && m_tready;
    assign fin      = (count_reg == total_reg - SW'(1));
    assign rend     = ((WW + 1)'(column_reg) + (WW + 1)'(1)) >= (WW + 1)'(eff_width);
    assign replays_inc = replays_reg + RW'(1);

    assign ram_we = accept && (s_tuser == phase_reg) && (s_tuser == ipru_pkg::FUNC_SOURCE);
    assign ram_re = accept && (s_tuser == phase_reg) && (s_tuser == ipru_pkg::FUNC_REPLAY);

    ipru_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (column_reg),
        .wdata (s_tdata[PW-1:0]),
        .rdata (ram_rdata)
    );

    assign m_tdata = {
        (ipru_pkg::M_DATA_W - PW - ipru_pkg::PAD_W)'(0),
        (fin && rend_reg) ? pad_reg : ipru_pkg::PAD_W'(0),
        pix_reg
    };
    assign m_tuser = {rej_reg, phase_reg, fin && rend_reg};
    assign m_tlast = fin;

    always_comb
    begin
        state_next   = state_reg;
        scale_next   = scale_reg;
        width_next   = width_reg;
        column_next  = column_reg;
        replays_next = replays_reg;
        phase_next   = phase_reg;
        count_next   = count_reg;
        total_next   = total_reg;
        pix_next     = pix_reg;
        pad_next     = pad_reg;
        rend_next    = rend_reg;
        rej_next     = rej_reg;

        if (cfg_we)
        begin
            unique case (ipru_pkg::cfg_index_t'(cfg_index))
                ipru_pkg::CFG_SCALE:     scale_next = cfg_data[SW-1:0];
                ipru_pkg::CFG_SRC_WIDTH: width_next = cfg_data[ipru_pkg::SRC_WIDTH_W-1:0];
                default:                 scale_next = scale_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    count_next = '0;
                    if (s_tuser != phase_reg)
                    begin
                        total_next = SW'(1);
                        pix_next   = '0;
                        rend_next  = 1'b0;
                        pad_next   = '0;
                        rej_next   = 1'b1;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        total_next = eff_scale;
                        rend_next  = rend;
                        pad_next   = ipru_pkg::pad_calc(eff_width[1:0], eff_scale[1:0]);
                        rej_next   = 1'b0;
                        if (s_tuser == ipru_pkg::FUNC_SOURCE)
                        begin
                            pix_next   = s_tdata[PW-1:0];
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            state_next = ST_READ;
                        end

                        if (rend)
                        begin
                            column_next = '0;
                            if (!phase_reg)
                            begin
                                if (eff_scale > SW'(1))
                                begin
                                    phase_next   = 1'b1;
                                    replays_next = '0;
                                end
                            end
                            else if ((replays_inc == '0)
                                     || (SW'(replays_inc) >= eff_scale - SW'(1)))
                            begin
                                phase_next   = 1'b0;
                                replays_next = '0;
                            end
                            else
                            begin
                                replays_next = replays_inc;
                            end
                        end
                        else
                        begin
                            column_next = column_reg + COL_W'(1);
                        end
                    end
                end
            end
            ST_READ:
            begin
                pix_next   = ram_rdata;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_fire)
                begin
                    if (fin)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        count_next = count_reg + SW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            scale_reg   <= SW'(1);
            width_reg   <= ipru_pkg::SRC_WIDTH_W'(1);
            column_reg  <= '0;
            replays_reg <= '0;
            phase_reg   <= 1'b0;
            count_reg   <= '0;
            total_reg   <= SW'(1);
            rend_reg    <= 1'b0;
            rej_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            scale_reg   <= scale_next;
            width_reg   <= width_next;
            column_reg  <= column_next;
            replays_reg <= replays_next;
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            rend_reg    <= rend_next;
            rej_reg     <= rej_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
        pad_reg <= pad_next;
    end

endmodule
